// ----- hdl/pqsg_pkg.sv -----
// Shared types and constants for the single-grant priority queue.
package pqsg_pkg;

    // Width of the queue count field in a response
    localparam int unsigned QCOUNT_BITS = 8;
    // Width of the status field in a response
    localparam int unsigned STATUS_BITS = 2;

    // Request function codes
    localparam logic FUNC_ENTER   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    // Response status codes
    localparam logic [STATUS_BITS-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_BITS-1:0] STAT_FULL     = 2'd1;
    localparam logic [STATUS_BITS-1:0] STAT_IDLE_REL = 2'd2;

    // Operation the datapath carries out for one request
    typedef enum logic [2:0] {
        OP_GRANT    = 3'd0,  // enter, resource free: grant at once
        OP_ENQ      = 3'd1,  // enter, resource held: insert in queue
        OP_DROP     = 3'd2,  // enter, queue full: drop
        OP_POP      = 3'd3,  // release, queue not empty: grant head
        OP_FREE     = 3'd4,  // release, queue empty: resource free
        OP_IDLE_REL = 3'd5   // release while resource free
    } op_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RESP = 2'b10
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic exec;
        op_t  op;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic busy;
        logic empty;
        logic full;
    } stat_t;

endpackage

// ----- hdl/pqsg_if.sv -----
// Request and response channel interfaces.
interface pqsg_req_if #(
    parameter int unsigned ID_BITS       = 16,
    parameter int unsigned PRIORITY_BITS = 8
);
    logic                     valid;
    logic                     ready;
    logic                     func;
    logic [ID_BITS-1:0]       requester_id;
    logic [PRIORITY_BITS-1:0] request_priority;

    modport source (output valid, func, requester_id, request_priority, input ready);
    modport sink   (input valid, func, requester_id, request_priority, output ready);
endinterface

interface pqsg_rsp_if
    import pqsg_pkg::*;
#(
    parameter int unsigned ID_BITS       = 16,
    parameter int unsigned PRIORITY_BITS = 8
);
    logic                     valid;
    logic                     ready;
    logic                     grant_valid;
    logic [ID_BITS-1:0]       grant_id;
    logic [PRIORITY_BITS-1:0] grant_priority;
    logic [QCOUNT_BITS-1:0]   queue_count;
    logic [STATUS_BITS-1:0]   status;

    modport source (output valid, grant_valid, grant_id, grant_priority, queue_count,
                    status, input ready);
    modport sink   (input valid, grant_valid, grant_id, grant_priority, queue_count,
                    status, output ready);
endinterface

// ----- hdl/pqsg_ctrl.sv -----
// Controller: request handshake, response hold and operation decode.
module pqsg_ctrl
    import pqsg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  in_func,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   accept;

    // A new request may enter while the pending response is taken
    assign in_ready  = (state_reg == ST_IDLE) || out_ready;
    assign out_valid = (state_reg == ST_RESP);
    assign accept    = in_valid && in_ready;

    // State transitions
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (accept)
                    state_next = ST_RESP;
                else if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Operation decode from function and queue status
    always_comb
    begin
        cmd.exec = accept;
        if (in_func == FUNC_ENTER)
        begin
            if (!stat.busy)
                cmd.op = OP_GRANT;
            else if (!stat.full)
                cmd.op = OP_ENQ;
            else
                cmd.op = OP_DROP;
        end
        else
        begin
            if (!stat.busy)
                cmd.op = OP_IDLE_REL;
            else if (!stat.empty)
                cmd.op = OP_POP;
            else
                cmd.op = OP_FREE;
        end
    end

endmodule

// ----- hdl/pqsg_datapath.sv -----
// Datapath: sorted row of compare-and-shift cells, count, busy flag, response registers.
module pqsg_datapath
    import pqsg_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH   = 128,
    parameter int unsigned ID_BITS       = 16,
    parameter int unsigned PRIORITY_BITS = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output stat_t                    stat,
    input  logic [ID_BITS-1:0]       in_id,
    input  logic [PRIORITY_BITS-1:0] in_prio,
    output logic                     grant_valid,
    output logic [ID_BITS-1:0]       grant_id,
    output logic [PRIORITY_BITS-1:0] grant_priority,
    output logic [QCOUNT_BITS-1:0]   queue_count,
    output logic [STATUS_BITS-1:0]   status
);

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    logic [PRIORITY_BITS-1:0] prio_reg [QUEUE_DEPTH];
    logic [ID_BITS-1:0]       id_reg   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]   gt;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [31:0]   cnt_ext;

    logic                     grant_valid_reg, grant_valid_next;
    logic [ID_BITS-1:0]       grant_id_reg, grant_id_next;
    logic [PRIORITY_BITS-1:0] grant_prio_reg, grant_prio_next;
    logic [QCOUNT_BITS-1:0]   count_out_reg;
    logic [STATUS_BITS-1:0]   status_reg, status_next;

    logic do_enq, do_pop;

    assign do_enq = cmd.exec && (cmd.op == OP_ENQ);
    assign do_pop = cmd.exec && (cmd.op == OP_POP);

    assign stat.busy  = busy_reg;
    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == CW'(QUEUE_DEPTH));

    // Cell row: each cell compares its own entry with the incoming priority
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic                     valid;
        logic                     prev_gt;
        logic [PRIORITY_BITS-1:0] prev_prio, next_prio;
        logic [ID_BITS-1:0]       prev_id, next_id;
        logic                     has_next;

        assign valid = (CW'(i) < cnt_reg);
        assign gt[i] = valid && (prio_reg[i] > in_prio);

        if (i > 0)
        begin : g_prev
            assign prev_gt   = gt[i-1];
            assign prev_prio = prio_reg[i-1];
            assign prev_id   = id_reg[i-1];
        end
        else
        begin : g_first
            assign prev_gt   = 1'b0;
            assign prev_prio = '0;
            assign prev_id   = '0;
        end

        if (i < QUEUE_DEPTH - 1)
        begin : g_next
            assign has_next  = 1'b1;
            assign next_prio = prio_reg[i+1];
            assign next_id   = id_reg[i+1];
        end
        else
        begin : g_last
            assign has_next  = 1'b0;
            assign next_prio = '0;
            assign next_id   = '0;
        end

        // Insert: larger entries move up one place, the new one lands at the boundary
        always_ff @(posedge clk)
        begin
            if (do_enq)
            begin
                if (prev_gt)
                begin
                    prio_reg[i] <= prev_prio;
                    id_reg[i]   <= prev_id;
                end
                else if (gt[i] || !valid)
                begin
                    prio_reg[i] <= in_prio;
                    id_reg[i]   <= in_id;
                end
            end
            else if (do_pop && has_next)
            begin
                prio_reg[i] <= next_prio;
                id_reg[i]   <= next_id;
            end
        end
    end

    // Next count, busy flag and response
    always_comb
    begin
        cnt_next         = cnt_reg;
        busy_next        = busy_reg;
        grant_valid_next = 1'b0;
        grant_id_next    = '0;
        grant_prio_next  = '0;
        status_next      = STAT_OK;
        case (cmd.op)
            OP_GRANT:
            begin
                busy_next        = 1'b1;
                grant_valid_next = 1'b1;
                grant_id_next    = in_id;
                grant_prio_next  = in_prio;
            end
            OP_ENQ:      cnt_next = cnt_reg + CW'(1);
            OP_DROP:     status_next = STAT_FULL;
            OP_POP:
            begin
                cnt_next         = cnt_reg - CW'(1);
                grant_valid_next = 1'b1;
                grant_id_next    = id_reg[0];
                grant_prio_next  = prio_reg[0];
            end
            OP_FREE:     busy_next = 1'b0;
            OP_IDLE_REL: status_next = STAT_IDLE_REL;
            default:     status_next = STAT_OK;
        endcase
    end

    assign cnt_ext = 32'(cnt_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    // Response registers, loaded once per request
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            grant_valid_reg <= grant_valid_next;
            grant_id_reg    <= grant_id_next;
            grant_prio_reg  <= grant_prio_next;
            count_out_reg   <= cnt_ext[QCOUNT_BITS-1:0];
            status_reg      <= status_next;
        end
    end

    assign grant_valid    = grant_valid_reg;
    assign grant_id       = grant_id_reg;
    assign grant_priority = grant_prio_reg;
    assign queue_count    = count_out_reg;
    assign status         = status_reg;

endmodule

// ----- hdl/priority_queue_single_grant.sv -----
// Top level of the single-grant priority queue.
//
//   Port  Dir  Carries
//   req   in   func, requester_id, request_priority  (valid/ready)
//   rsp   out  grant_valid, grant_id, grant_priority, queue_count, status  (valid/ready)
//
// Each request is executed in the cycle it is accepted: every queue cell compares
// and shifts in parallel, and the response is registered for the next cycle.
// One request per cycle when the response side takes each response as it appears;
// a new request is accepted in the same cycle the pending response is taken.
// A stalled response holds the request side off. No clearing pass after reset:
// only the controller state, the count and the busy flag are reset.
module priority_queue_single_grant
    import pqsg_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH   = 128,
    parameter int unsigned ID_BITS       = 16,
    parameter int unsigned PRIORITY_BITS = 8
) (
    input logic       clk,
    input logic       rst_n,
    pqsg_req_if.sink  req,
    pqsg_rsp_if.source rsp
);

    cmd_t  cmd;
    stat_t stat;

    pqsg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_func   (req.func),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pqsg_datapath #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .ID_BITS       (ID_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_id          (req.requester_id),
        .in_prio        (req.request_priority),
        .grant_valid    (rsp.grant_valid),
        .grant_id       (rsp.grant_id),
        .grant_priority (rsp.grant_priority),
        .queue_count    (rsp.queue_count),
        .status         (rsp.status)
    );

    // Every accepted request has its response pending in the next cycle
    a_resp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> rsp.valid)
        else $error("no response after accepted request");

    // Without a grant the grant fields read zero
    a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.grant_valid) |-> (rsp.grant_id == '0 && rsp.grant_priority == '0))
        else $error("grant fields nonzero without grant");

    // A dropped request grants nothing and reports a full queue
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == STAT_FULL)
            |-> (!rsp.grant_valid && rsp.queue_count == QCOUNT_BITS'(QUEUE_DEPTH)))
        else $error("drop reported without full queue");

    // A grant always comes with ok status
    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.grant_valid) |-> (rsp.status == STAT_OK))
        else $error("grant with error status");

endmodule

// ----- test/pqsg_checker.sv -----
// Request/response monitor with arbitration predictor and in-order compare.
module pqsg_checker
    import pqsg_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH   = 128,
    parameter int unsigned ID_BITS       = 16,
    parameter int unsigned PRIORITY_BITS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    pqsg_req_if        req,
    pqsg_rsp_if        rsp,
    output int         fail_count,
    output int         outstanding
);

    typedef struct packed {
        logic                     grant_valid;
        logic [ID_BITS-1:0]       grant_id;
        logic [PRIORITY_BITS-1:0] grant_priority;
        logic [QCOUNT_BITS-1:0]   queue_count;
        logic [STATUS_BITS-1:0]   status;
    } grant_result_t;

    // Predicted arbiter state
    logic [PRIORITY_BITS-1:0] wait_prio [QUEUE_DEPTH];
    logic [ID_BITS-1:0]       wait_id   [QUEUE_DEPTH];
    int                       wait_count;
    logic                     holder_busy;

    grant_result_t pending_results [$];

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
    end

    task automatic flag_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // Apply one request to the predicted state and return its response
    function automatic grant_result_t arbitrate(input logic f,
                                                input logic [ID_BITS-1:0] id,
                                                input logic [PRIORITY_BITS-1:0] pr);
        grant_result_t r;
        int pos;
        r = '0;
        r.status = STAT_OK;
        if (f == FUNC_ENTER)
        begin
            if (!holder_busy)
            begin
                holder_busy      = 1'b1;
                r.grant_valid    = 1'b1;
                r.grant_id       = id;
                r.grant_priority = pr;
            end
            else if (wait_count < int'(QUEUE_DEPTH))
            begin
                // insert behind every entry of equal or lower value
                pos = wait_count;
                while (pos > 0 && wait_prio[pos-1] > pr)
                begin
                    wait_prio[pos] = wait_prio[pos-1];
                    wait_id[pos]   = wait_id[pos-1];
                    pos--;
                end
                wait_prio[pos] = pr;
                wait_id[pos]   = id;
                wait_count++;
            end
            else
            begin
                r.status = STAT_FULL;
            end
        end
        else
        begin
            if (!holder_busy)
            begin
                r.status = STAT_IDLE_REL;
            end
            else if (wait_count > 0)
            begin
                // hand over to the head and remove it
                r.grant_valid    = 1'b1;
                r.grant_id       = wait_id[0];
                r.grant_priority = wait_prio[0];
                for (int k = 1; k < wait_count; k++)
                begin
                    wait_prio[k-1] = wait_prio[k];
                    wait_id[k-1]   = wait_id[k];
                end
                wait_count--;
            end
            else
            begin
                holder_busy = 1'b0;
            end
        end
        r.queue_count = QCOUNT_BITS'(wait_count);
        return r;
    endfunction

    // Compare responses first, then predict the request taken at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        grant_result_t want;
        if (!rst_n)
        begin
            wait_count  = 0;
            holder_busy = 1'b0;
            pending_results.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    flag_mismatch("response with no request pending");
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp.grant_valid !== want.grant_valid)
                        flag_mismatch($sformatf("grant_valid expected %0h, got %0h",
                                                want.grant_valid, rsp.grant_valid));
                    if (rsp.grant_id !== want.grant_id)
                        flag_mismatch($sformatf("grant_id expected %0h, got %0h",
                                                want.grant_id, rsp.grant_id));
                    if (rsp.grant_priority !== want.grant_priority)
                        flag_mismatch($sformatf("grant_priority expected %0h, got %0h",
                                                want.grant_priority, rsp.grant_priority));
                    if (rsp.queue_count !== want.queue_count)
                        flag_mismatch($sformatf("queue_count expected %0d, got %0d",
                                                want.queue_count, rsp.queue_count));
                    if (rsp.status !== want.status)
                        flag_mismatch($sformatf("status expected %0d, got %0d",
                                                want.status, rsp.status));
                end
            end
            if (req.valid && req.ready)
                pending_results.push_back(arbitrate(req.func, req.requester_id,
                                                    req.request_priority));
        end
        outstanding = pending_results.size();
    end

endmodule

// ----- test/tb_priority_queue_single_grant.sv -----
// Top of the priority queue testbench: clock, reset, stimulus and verdict.
module tb_priority_queue_single_grant
    import pqsg_pkg::*;
();

    localparam int unsigned QUEUE_DEPTH   = 128;
    localparam int unsigned ID_BITS       = 16;
    localparam int unsigned PRIORITY_BITS = 8;
    localparam int          ITEM_TARGET   = 1800;

    typedef enum int {
        SEG_MIXED,
        SEG_FILL,
        SEG_DRAIN
    } seg_kind_t;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   outstanding;
    int   sent;
    int   gap_odds;
    int   stall_odds;

    pqsg_req_if #(.ID_BITS(ID_BITS), .PRIORITY_BITS(PRIORITY_BITS)) req_ch ();
    pqsg_rsp_if #(.ID_BITS(ID_BITS), .PRIORITY_BITS(PRIORITY_BITS)) rsp_ch ();

    priority_queue_single_grant #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .ID_BITS       (ID_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    pqsg_checker #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .ID_BITS       (ID_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit: far above the slowest correct run
    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Response side: ready with random stall bursts
    initial
    begin
        int stall_left;
        stall_left   = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_odds != 0 && $urandom_range(0, 15) < stall_odds)
            begin
                stall_left = $urandom_range(1, 16) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Present one request, with an optional idle burst ahead of it
    task automatic send_request(input logic f, input logic [ID_BITS-1:0] id,
                                input logic [PRIORITY_BITS-1:0] pr);
        int gap;
        if (gap_odds != 0 && $urandom_range(0, 7) < gap_odds)
        begin
            gap = $urandom_range(1, 16);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid            <= 1'b1;
        req_ch.func             <= f;
        req_ch.requester_id     <= id;
        req_ch.request_priority <= pr;
        do
            @(posedge clk);
        while (!(req_ch.valid && req_ch.ready));
        sent++;
        @(negedge clk);
    endtask

    initial
    begin
        seg_kind_t kind;
        int        seg;
        int        n;
        int        enter_pct;
        int        prio_span;
        logic      f;

        sent                    = 0;
        gap_odds                = 0;
        stall_odds              = 0;
        rst_n                   = 1'b0;
        req_ch.valid            <= 1'b0;
        req_ch.func             <= FUNC_ENTER;
        req_ch.requester_id     <= '0;
        req_ch.request_priority <= '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: idle release, field extremes, ties, drain to empty and free
        send_request(FUNC_RELEASE, ID_BITS'($urandom), PRIORITY_BITS'($urandom));
        send_request(FUNC_ENTER, 16'h0000, 8'h00);
        send_request(FUNC_ENTER, 16'hFFFF, 8'hFF);
        send_request(FUNC_ENTER, 16'h1234, 8'h00);
        send_request(FUNC_ENTER, 16'h5555, 8'h80);
        send_request(FUNC_ENTER, 16'hAAAA, 8'h80);
        send_request(FUNC_ENTER, 16'h0001, 8'hFF);
        repeat (6)
            send_request(FUNC_RELEASE, ID_BITS'($urandom), PRIORITY_BITS'($urandom));
        send_request(FUNC_RELEASE, ID_BITS'($urandom), PRIORITY_BITS'($urandom));
        send_request(FUNC_ENTER, 16'hFFFF, 8'hFF);
        send_request(FUNC_ENTER, 16'h0000, 8'h00);
        send_request(FUNC_RELEASE, 16'hFFFF, 8'hFF);
        send_request(FUNC_RELEASE, 16'h0000, 8'h00);

        // Random segments; the first two fill past full and drain past idle
        seg = 0;
        while (sent < ITEM_TARGET)
        begin
            if (seg == 0)
                kind = SEG_FILL;
            else if (seg == 1)
                kind = SEG_DRAIN;
            else
            begin
                n = $urandom_range(0, 5);
                kind = (n == 4) ? SEG_FILL : (n == 5) ? SEG_DRAIN : SEG_MIXED;
            end
            // no idling in the last part of the run
            if (sent > ITEM_TARGET * 4 / 5)
            begin
                gap_odds   = 0;
                stall_odds = 0;
            end
            else
            begin
                gap_odds   = $urandom_range(0, 3);
                stall_odds = $urandom_range(0, 3);
            end
            prio_span = $urandom_range(0, 1) ? 255 : 3;
            case (kind)
                SEG_FILL:
                begin
                    n = QUEUE_DEPTH + $urandom_range(3, 10);
                    enter_pct = 100;
                end
                SEG_DRAIN:
                begin
                    n = QUEUE_DEPTH + $urandom_range(2, 6);
                    enter_pct = 0;
                end
                default:
                begin
                    n = $urandom_range(20, 80);
                    enter_pct = $urandom_range(35, 70);
                end
            endcase
            repeat (n)
            begin
                f = ($urandom_range(0, 99) < enter_pct) ? FUNC_ENTER : FUNC_RELEASE;
                send_request(f, ID_BITS'($urandom),
                             PRIORITY_BITS'($urandom_range(0, prio_span)));
            end
            seg++;
        end
        req_ch.valid <= 1'b0;
        gap_odds   = 0;
        stall_odds = 0;

        // Let every response come back, then a short settle
        wait (outstanding == 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/pqsg_pkg.sv
hdl/pqsg_if.sv
hdl/pqsg_ctrl.sv
hdl/pqsg_datapath.sv
hdl/priority_queue_single_grant.sv
test/pqsg_checker.sv
test/tb_priority_queue_single_grant.sv
